[hw/rtl/c3g_pkg.sv]
package c3g_pkg;

    localparam int PIX_BITS      = 8;
    localparam int SLOT_BITS     = 16;
    localparam int COEF_SET_BITS = 48;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int ROW_BITS      = 13;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int N_TAPS        = 3;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 16;

    localparam logic [FW_BITS-1:0]       FRAME_WIDTH_RST  = FW_BITS'(256);
    localparam logic [FH_BITS-1:0]       FRAME_HEIGHT_RST = FH_BITS'(256);
    localparam logic [COEF_SET_BITS-1:0] COEF_SET_0_RST   = '0;
    localparam logic [COEF_SET_BITS-1:0] COEF_SET_1_RST   = COEF_SET_BITS'(256);
    localparam logic [COEF_SET_BITS-1:0] COEF_SET_2_RST   = '0;

    typedef logic [PIX_BITS-1:0] pix_t;

    // one window column, index 0 is the oldest row, 2 the newest
    typedef logic [N_TAPS-1:0][PIX_BITS-1:0] col_t;

    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } lpair_t;

    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } ctl_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_SET_0   = 3'd2,
        REG_COEF_SET_1   = 3'd3,
        REG_COEF_SET_2   = 3'd4
    } reg_idx_t;

endpackage

[hw/rtl/c3g_linebuf.sv]
module c3g_linebuf import c3g_pkg::*; #(
    parameter int DEPTH     = MAX_WIDTH_DEF,
    parameter int ADDR_BITS = $clog2(MAX_WIDTH_DEF)
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  lpair_t               wr_data,
    output lpair_t               rd_data
);

    lpair_t line_mem [DEPTH];
    lpair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    // same-address write in the read cycle is bypassed (single-column frames)
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/c3g_cell.sv]
module c3g_cell import c3g_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int PSUM_BITS = COEF_BITS_DEF + PIX_BITS + 3
) (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  col_t                        col_in,
    input  logic [COEF_SET_BITS-1:0]    coef_set,
    output col_t                        col_out,
    output logic signed [PSUM_BITS-1:0] psum
);

    localparam int PROD_BITS = COEF_BITS + PIX_BITS + 1;

    col_t                        col_reg;
    logic signed [PSUM_BITS-1:0] psum_reg;
    logic signed [PSUM_BITS-1:0] psum_next;
    logic signed [COEF_BITS-1:0] wt   [N_TAPS];
    logic signed [PROD_BITS-1:0] prod [N_TAPS];
    logic signed [PSUM_BITS-1:0] ext  [N_TAPS];

    // row r uses weight slot 2 - r
    always_comb begin
        for (int r = 0; r < N_TAPS; r++) begin
            wt[r]   = $signed(coef_set[SLOT_BITS*(N_TAPS-1-r) +: COEF_BITS]);
            prod[r] = $signed({{(PROD_BITS-PIX_BITS){1'b0}}, col_in[r]})
                      * PROD_BITS'(wt[r]);
            ext[r]  = PSUM_BITS'(prod[r]);
        end
        psum_next = ext[0] + ext[1] + ext[2];
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg  <= col_in;
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

[hw/rtl/conv3x3_grey_stream_core.sv]
// 3x3 convolution over a grey pixel stream, one word per clock sustained while the output is not stalled
// a result is registered in stage 1, then in the cell chain, then in the output register
// first result appears after frame width + 1 words; flush words drain the last row
// the line store has separate read and write ports: one read and one write a cycle
// reset (aresetn low, synchronous) clears counters, pipeline valids and the registers
// to their defaults; line stores are not cleared, their unwritten entries only feed border
module conv3x3_grey_stream_core import c3g_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // pixel input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_BITS-1:0]      s_pixel_in,
    input  logic                     s_flush,
    // filtered output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [PIX_BITS-1:0]      m_pixel_out,
    output logic                     m_last_of_frame
);

    // width count, line store address, item count widths
    localparam int WB        = $clog2(MAX_WIDTH + 1);
    localparam int AB        = $clog2(MAX_WIDTH);
    localparam int CW        = (WB > FW_BITS) ? WB : FW_BITS;
    localparam int KB        = $clog2(MAX_WIDTH * (HEIGHT_LIMIT + 1) + 1);
    localparam int PSUM_BITS = COEF_BITS + PIX_BITS + 3;
    localparam int ACC_BITS  = PSUM_BITS + 2;
    localparam logic signed [ACC_BITS-1:0] SAT_LIMIT = ACC_BITS'(255 * 256);

    // ---------------- configuration registers ----------------
    logic [FW_BITS-1:0]       frame_width_reg;
    logic [FH_BITS-1:0]       frame_height_reg;
    logic [COEF_SET_BITS-1:0] coef_reg [N_TAPS];
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            coef_reg[0]      <= COEF_SET_0_RST;
            coef_reg[1]      <= COEF_SET_1_RST;
            coef_reg[2]      <= COEF_SET_2_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_BITS-1:0];
                REG_COEF_SET_0:   coef_reg[0]      <= pwdata[COEF_SET_BITS-1:0];
                REG_COEF_SET_1:   coef_reg[1]      <= pwdata[COEF_SET_BITS-1:0];
                REG_COEF_SET_2:   coef_reg[2]      <= pwdata[COEF_SET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height_reg);
            REG_COEF_SET_0:   prdata = APB_DATA_BITS'(coef_reg[0]);
            REG_COEF_SET_1:   prdata = APB_DATA_BITS'(coef_reg[1]);
            REG_COEF_SET_2:   prdata = APB_DATA_BITS'(coef_reg[2]);
            default:          prdata = '0;
        endcase
    end

    // ---------------- effective frame size ----------------
    logic [WB-1:0]      w_eff;
    logic [FH_BITS-1:0] h_eff;
    logic [KB-1:0]      last_index;

    // width saturated to 1..MAX_WIDTH, height to 1..HEIGHT_LIMIT
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WB'(1);
        end else if (CW'(frame_width_reg) > CW'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = FH_BITS'(1);
        end else if (frame_height_reg > FH_BITS'(HEIGHT_LIMIT)) begin
            h_eff = FH_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = frame_height_reg;
        end
        last_index = KB'(w_eff) * KB'(h_eff) + KB'(w_eff);
    end

    // ---------------- handshake and pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic ready_out, ready_s2, accept, s1_move;

    assign ready_out = !m_valid_reg || m_ready;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign s_ready   = !s1_valid_reg || ready_s2;
    assign accept    = s_valid && s_ready;
    assign s1_move   = s1_valid_reg && ready_s2;

    // ---------------- position counters ----------------
    logic [KB-1:0]       items_reg, items_next;
    logic [AB-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [WB-1:0]       col_inc;
    ctl_t                ctl_in;

    always_comb begin
        col_inc       = WB'(col_reg) + WB'(1);
        ctl_in.emit   = items_reg >= (KB'(w_eff) + KB'(1));
        ctl_in.last   = items_reg >= last_index;
        // centre column is col - 1 and centre row is row - 1 (or row - 2 at column 0)
        ctl_in.border = (col_reg <= AB'(1)) || (WB'(col_reg) >= w_eff)
                     || (row_reg <= ROW_BITS'(1)) || (row_reg >= ROW_BITS'(h_eff));

        items_next = items_reg + KB'(1);
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = row_reg + ROW_BITS'(1);
        end else begin
            col_next = col_inc[AB-1:0];
            row_next = row_reg;
        end
        // final word of the frame restarts the count
        if (ctl_in.emit && ctl_in.last) begin
            items_next = '0;
            col_next   = '0;
            row_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            items_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (accept) begin
            items_reg <= items_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    pix_t          s1_sample_reg;
    logic [AB-1:0] s1_addr_reg;
    ctl_t          s1_ctl_reg;
    lpair_t        lb_rd;
    lpair_t        lb_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // a flush word enters as a zero sample
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= s_flush ? '0 : s_pixel_in;
            s1_addr_reg   <= col_reg;
            s1_ctl_reg    <= ctl_in;
        end
    end

    // older line moves up, new sample goes into the lower line
    assign lb_wr.upper = lb_rd.lower;
    assign lb_wr.lower = s1_sample_reg;

    c3g_linebuf #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (AB)
    ) u_linebuf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // ---------------- stage 2: window column chain ----------------
    col_t                        col_link [N_TAPS];
    logic signed [PSUM_BITS-1:0] psum_w   [N_TAPS];
    ctl_t                        s2_ctl_reg;

    assign col_link[0] = {s1_sample_reg, lb_rd.lower, lb_rd.upper};

    // cell 0 holds the newest column, cell 2 the oldest
    for (genvar i = 0; i < N_TAPS; i++) begin : g_cell
        if (i < N_TAPS - 1) begin : g_mid
            c3g_cell #(
                .COEF_BITS (COEF_BITS),
                .PSUM_BITS (PSUM_BITS)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (s1_move),
                .col_in   (col_link[i]),
                .coef_set (coef_reg[i]),
                .col_out  (col_link[i+1]),
                .psum     (psum_w[i])
            );
        end else begin : g_end
            c3g_cell #(
                .COEF_BITS (COEF_BITS),
                .PSUM_BITS (PSUM_BITS)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (s1_move),
                .col_in   (col_link[i]),
                .coef_set (coef_reg[i]),
                .col_out  (),
                .psum     (psum_w[i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ready_s2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // ---------------- output: sum, clamp, register ----------------
    logic signed [ACC_BITS-1:0] acc;
    pix_t                       pix_next;
    pix_t                       m_pixel_reg;
    logic                       m_last_reg;

    always_comb begin
        acc = ACC_BITS'(psum_w[0]) + ACC_BITS'(psum_w[1]) + ACC_BITS'(psum_w[2]);
        if (s2_ctl_reg.border || acc[ACC_BITS-1]) begin
            pix_next = '0;
        end else if (acc >= SAT_LIMIT) begin
            pix_next = '1;
        end else begin
            pix_next = acc[2*PIX_BITS-1:PIX_BITS];
        end
    end

    // words before the window fills are consumed without a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_out) begin
            m_valid_reg <= s2_valid_reg && s2_ctl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && s2_valid_reg) begin
            m_pixel_reg <= pix_next;
            m_last_reg  <= s2_ctl_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = m_pixel_reg;
    assign m_last_of_frame = m_last_reg;

endmodule
